/* rtl/atn_pkg.sv */
// ----------------------------------------------------------------------------
// atn_pkg
// Shared widths, codes and the configuration status group for the node table.
// ----------------------------------------------------------------------------
package atn_pkg;

	// Defaults and limits of the top-level parameters
	localparam int NODES_DEF      = 256;
	localparam int VALUE_BITS_DEF = 32;
	localparam int NODES_MAX      = 4096;

	// Fixed field widths of the request and response channels
	localparam int ACTION_BITS = 3;
	localparam int POS_BITS    = 8;
	localparam int SPAN_BITS   = 9;
	localparam int DATA_BITS   = 32;
	localparam int STATUS_BITS = 2;
	localparam int INDEX_BITS  = 8;
	localparam int CHILD_BITS  = 4;
	localparam int DEPTH_BITS  = 3;
	localparam int TCOUNT_BITS = 9;

	// Configuration port
	localparam int CFG_BITS  = 4;
	localparam int ADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam int CAP_BITS  = $clog2(NODES_MAX + 1) + 1;

	localparam logic [CFG_BITS-1:0] FANOUT_RST = 4'd3;
	localparam logic [CFG_BITS-1:0] LEVELS_RST = 4'd3;

	// Register index, taken from the word address
	localparam logic REG_FANOUT = 1'b0;
	localparam logic REG_LEVELS = 1'b1;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_CLEAR  = 3'd0,
		ACT_ROOT   = 3'd1,
		ACT_ADD    = 3'd2,
		ACT_SEARCH = 3'd3,
		ACT_READ   = 3'd4
	} action_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// Configuration view handed to the sequencer
	typedef struct packed {
		logic                busy;
		logic [CFG_BITS-1:0] levels;
		logic [CAP_BITS-1:0] capacity;
	} cfg_t;

endpackage

/* rtl/atn_req_if.sv */
// ----------------------------------------------------------------------------
// atn_req_if
// Request channel of the node table: one action with its operands.
// ----------------------------------------------------------------------------
interface atn_req_if import atn_pkg::*; ();

	logic                   valid;
	logic                   ready;
	logic [ACTION_BITS-1:0] action;
	logic [POS_BITS-1:0]    position;
	logic [SPAN_BITS-1:0]   span;
	logic [DATA_BITS-1:0]   value;

	modport source (output valid, output action, output position, output span,
		output value, input ready);
	modport sink (input valid, input action, input position, input span,
		input value, output ready);

endinterface

/* rtl/atn_rsp_if.sv */
// ----------------------------------------------------------------------------
// atn_rsp_if
// Response channel of the node table: one result per request.
// ----------------------------------------------------------------------------
interface atn_rsp_if import atn_pkg::*; ();

	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [INDEX_BITS-1:0]  result_index;
	logic [DATA_BITS-1:0]   node_value;
	logic [INDEX_BITS-1:0]  parent_index;
	logic                   has_parent;
	logic [INDEX_BITS-1:0]  first_child_index;
	logic [CHILD_BITS-1:0]  child_total;
	logic [DEPTH_BITS-1:0]  node_depth;
	logic [TCOUNT_BITS-1:0] table_count;
	logic [DATA_BITS-1:0]   tree_count;

	modport source (output valid, output status, output result_index,
		output node_value, output parent_index, output has_parent,
		output first_child_index, output child_total, output node_depth,
		output table_count, output tree_count, input ready);
	modport sink (input valid, input status, input result_index,
		input node_value, input parent_index, input has_parent,
		input first_child_index, input child_total, input node_depth,
		input table_count, input tree_count, output ready);

endinterface

/* rtl/array_tree_node_store.sv */
// ----------------------------------------------------------------------------
// array_tree_node_store
// Node table for the top levels of an n-ary tree: clear, set root, add child,
// search a span for a value and read a node, one request at a time.
//
//   channel  dir  handshake                  carries
//   req      in   req.valid / req.ready      action, position, span, value
//   rsp      out  rsp.valid / rsp.ready      status, node fields, counts
//   apb      in   psel/penable/pwrite/pready fanout (0x0), table_levels (0x4)
//
// Clear, set root, unknown actions and an add or read with an index out of
// range go straight from acceptance to the result step; read passes a fetch
// step, add a fetch and, if the child fits, a link step (the parent update
// is a second write on the single memory write port). Search reads one entry
// per cycle and stops at the first match or, with none, at the end of the
// span (ending early at the last held entry). Reset and each register write
// start the capacity sum, which runs one level per cycle with req.ready low.
// A new request is taken while the previous result waits in the output
// register; a stalled result holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module array_tree_node_store import atn_pkg::*; #(
	parameter int NODES      = NODES_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	atn_req_if.sink               req,
	atn_rsp_if.source             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_BITS-1:0]  paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	cfg_t cfg;

	// Registers and capacity
	atn_cfg #(
		.NODES (NODES)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Node memory and sequencer
	atn_ctrl #(
		.NODES      (NODES),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

/* rtl/atn_cfg.sv */
// ----------------------------------------------------------------------------
// atn_cfg
// Configuration registers on the APB port and the table capacity unit, which
// sums fanout^L one level per cycle after reset and after every write.
// ----------------------------------------------------------------------------
module atn_cfg import atn_pkg::*; #(
	parameter int NODES = NODES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_BITS-1:0]  paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	localparam int CW = $clog2(NODES + 1) + 1;
	localparam int PW = CW + CFG_BITS;
	localparam logic [CW-1:0] NODES_C = CW'(NODES);

	logic [CFG_BITS-1:0] fanout_q;
	logic [CFG_BITS-1:0] levels_q;
	logic [CFG_BITS-1:0] lv_q;
	logic [CW-1:0]       cap_q;
	logic [CW-1:0]       lsize_q;
	logic                busy_q;

	logic          wr;
	logic          reg_sel;
	logic [CW-1:0] sum;
	logic [PW-1:0] prod;
	logic [CW-1:0] prod_cap;

	// Decode the write and form one level step of the capacity sum
	always_comb begin
		wr       = psel & penable & pwrite;
		reg_sel  = paddr[ADDR_BITS-1];
		sum      = cap_q + lsize_q;
		prod     = PW'(lsize_q) * PW'(fanout_q);
		prod_cap = (prod > PW'(NODES)) ? NODES_C : CW'(prod);
	end

	// Hold the registers and advance the capacity sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fanout_q <= FANOUT_RST;
			levels_q <= LEVELS_RST;
			lv_q     <= '0;
			cap_q    <= '0;
			lsize_q  <= CW'(1);
			busy_q   <= 1'b1;
		end else if (wr) begin
			case (reg_sel)
				REG_FANOUT: fanout_q <= pwdata[CFG_BITS-1:0];
				REG_LEVELS: levels_q <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
			lv_q    <= '0;
			cap_q   <= '0;
			lsize_q <= CW'(1);
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			if (lv_q >= levels_q) begin
				busy_q <= 1'b0;
			end else if (sum >= NODES_C) begin
				cap_q  <= NODES_C;
				busy_q <= 1'b0;
			end else begin
				cap_q   <= sum;
				lsize_q <= prod_cap;
				lv_q    <= lv_q + CFG_BITS'(1);
			end
		end
	end

	// Read back and status view
	always_comb begin
		case (reg_sel)
			REG_FANOUT: prdata = PDATA_BITS'(fanout_q);
			REG_LEVELS: prdata = PDATA_BITS'(levels_q);
			default:    prdata = '0;
		endcase
		pready       = 1'b1;
		cfg.busy     = busy_q;
		cfg.levels   = levels_q;
		cfg.capacity = CAP_BITS'(cap_q);
	end

endmodule

/* rtl/atn_ctrl.sv */
// ----------------------------------------------------------------------------
// atn_ctrl
// Node memory and the sequencer that reads, modifies and writes it back for
// each request, walks a search span one entry per cycle and holds the result.
// ----------------------------------------------------------------------------
module atn_ctrl import atn_pkg::*; #(
	parameter int NODES      = NODES_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	atn_req_if.sink      req,
	atn_rsp_if.source    rsp
);

	localparam int VW = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;
	localparam int IW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1) + 1;
	localparam int EW = (CW > 10) ? CW : 10;

	typedef struct packed {
		logic [VW-1:0]         value;
		logic [IW-1:0]         parent;
		logic [IW-1:0]         first_child;
		logic [CHILD_BITS-1:0] kids;
		logic [DEPTH_BITS-1:0] depth;
	} node_t;

	typedef struct packed {
		status_t                status;
		logic [INDEX_BITS-1:0]  result_index;
		logic [DATA_BITS-1:0]   node_value;
		logic [INDEX_BITS-1:0]  parent_index;
		logic                   has_parent;
		logic [INDEX_BITS-1:0]  first_child_index;
		logic [CHILD_BITS-1:0]  child_total;
		logic [DEPTH_BITS-1:0]  node_depth;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_LINK,
		S_SEARCH,
		S_DONE
	} state_t;

	// Node memory
	node_t mem [NODES];
	node_t rd_s1;

	logic [EW-1:0] rd_idx_s1;
	logic          rd_valid_s1;

	state_t                 state_q;
	action_t                act_q;
	logic [POS_BITS-1:0]    pos_q;
	logic [VW-1:0]          val_q;
	logic [EW-1:0]          e_q;
	logic [SPAN_BITS-1:0]   rem_q;
	node_t                  parent_q;
	logic [CW-1:0]          used_q;
	logic [DATA_BITS-1:0]   all_q;
	result_t                res_q;
	result_t                out_q;
	logic [TCOUNT_BITS-1:0] out_table_q;
	logic [DATA_BITS-1:0]   out_tree_q;
	logic                   out_valid_q;

	logic                  req_ok;
	logic                  accept;
	action_t               in_act;
	logic [EW-1:0]         pos_ext;
	logic                  pos_in_range;
	result_t               res_init;
	logic                  out_load;
	logic                  issue;
	logic                  hit;
	logic                  fits;
	logic [CFG_BITS-1:0]   depth_next;
	logic [DEPTH_BITS-1:0] child_depth;
	logic [DATA_BITS-1:0]  all_inc;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	node_t                 mem_wdata;
	logic                  mem_re;
	logic [IW-1:0]         mem_raddr;

	// Request decode and checks on the fetched entry
	always_comb begin
		req_ok       = (state_q == S_IDLE) && !cfg.busy;
		accept       = req.valid && req_ok;
		in_act       = action_t'(req.action);
		pos_ext      = EW'(req.position);
		pos_in_range = pos_ext < EW'(used_q);
		out_load     = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
		issue        = (state_q == S_SEARCH) && (rem_q != '0) && (e_q < EW'(used_q));
		hit          = rd_valid_s1 && (rd_s1.value == val_q);
		depth_next   = CFG_BITS'(rd_s1.depth) + CFG_BITS'(1);
		child_depth  = (rd_s1.depth == '1) ? rd_s1.depth : rd_s1.depth + DEPTH_BITS'(1);
		fits         = (depth_next < cfg.levels) && (CAP_BITS'(used_q) < cfg.capacity);
		all_inc      = (all_q == '1) ? all_q : all_q + DATA_BITS'(1);
		// flag an out-of-range index or an unknown action up front
		res_init = '0;
		case (in_act)
			ACT_CLEAR, ACT_ROOT, ACT_SEARCH: ;
			ACT_ADD, ACT_READ: begin
				if (!pos_in_range) begin
					res_init.status = ST_RANGE;
				end
			end
			default: res_init.status = ST_RANGE;
		endcase
	end

	// Memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && in_act == ACT_ROOT) begin
					mem_we          = 1'b1;
					mem_wdata.value = VW'(req.value);
				end
				if (accept && (in_act == ACT_ADD || in_act == ACT_READ)) begin
					mem_re    = 1'b1;
					mem_raddr = IW'(req.position);
				end
			end
			S_FETCH: begin
				if (act_q == ACT_ADD && fits) begin
					mem_we          = 1'b1;
					mem_waddr       = IW'(used_q);
					mem_wdata.value = val_q;
					mem_wdata.parent = IW'(pos_q);
					mem_wdata.depth = child_depth;
				end
			end
			S_LINK: begin
				mem_we    = 1'b1;
				mem_waddr = IW'(pos_q);
				mem_wdata = parent_q;
			end
			S_SEARCH: begin
				mem_re    = issue && !hit;
				mem_raddr = IW'(e_q);
			end
			default: ;
		endcase
	end

	// Write and read the node memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_s1 <= mem[mem_raddr];
		end
	end

	// Sequencer, counters and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			all_q       <= '0;
			out_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SEARCH) && issue && !hit;
			out_valid_q <= out_load || (out_valid_q && !rsp.ready);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q <= in_act;
						pos_q <= req.position;
						val_q <= VW'(req.value);
						e_q   <= pos_ext;
						rem_q <= req.span;
						res_q <= res_init;
						case (in_act)
							ACT_CLEAR: begin
								used_q  <= '0;
								all_q   <= '0;
								state_q <= S_DONE;
							end
							ACT_ROOT: begin
								used_q  <= CW'(1);
								all_q   <= DATA_BITS'(1);
								state_q <= S_DONE;
							end
							ACT_ADD, ACT_READ: begin
								state_q <= pos_in_range ? S_FETCH : S_DONE;
							end
							ACT_SEARCH: state_q <= S_SEARCH;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FETCH: begin
					if (act_q == ACT_READ) begin
						res_q.result_index <= pos_q;
						res_q.node_value   <= DATA_BITS'(rd_s1.value);
						res_q.parent_index <= INDEX_BITS'(rd_s1.parent);
						res_q.has_parent   <= (pos_q != '0);
						res_q.first_child_index <= (rd_s1.kids != '0) ?
							INDEX_BITS'(rd_s1.first_child) : '0;
						res_q.child_total  <= rd_s1.kids;
						res_q.node_depth   <= rd_s1.depth;
						state_q            <= S_DONE;
					end else if (fits) begin
						// place the child and queue the parent update
						parent_q.value  <= rd_s1.value;
						parent_q.parent <= rd_s1.parent;
						parent_q.depth  <= rd_s1.depth;
						parent_q.first_child <= (rd_s1.kids == '0) ?
							IW'(used_q) : rd_s1.first_child;
						parent_q.kids <= (rd_s1.kids == '1) ?
							rd_s1.kids : rd_s1.kids + CHILD_BITS'(1);
						res_q.result_index <= INDEX_BITS'(used_q);
						used_q  <= used_q + CW'(1);
						all_q   <= all_inc;
						state_q <= S_LINK;
					end else begin
						all_q        <= all_inc;
						res_q.status <= ST_OVERFLOW;
						state_q      <= S_DONE;
					end
				end
				S_LINK: state_q <= S_DONE;
				S_SEARCH: begin
					if (hit) begin
						res_q.status       <= ST_OK;
						res_q.result_index <= INDEX_BITS'(rd_idx_s1);
						state_q            <= S_DONE;
					end else if (!issue) begin
						res_q.status <= ST_NOT_FOUND;
						state_q      <= S_DONE;
					end else begin
						rd_idx_s1 <= e_q;
						e_q       <= e_q + EW'(1);
						rem_q     <= rem_q - SPAN_BITS'(1);
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_q       <= res_q;
						out_table_q <= TCOUNT_BITS'(used_q);
						out_tree_q  <= all_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Drive the channels
	assign req.ready             = req_ok;
	assign rsp.valid             = out_valid_q;
	assign rsp.status            = out_q.status;
	assign rsp.result_index      = out_q.result_index;
	assign rsp.node_value        = out_q.node_value;
	assign rsp.parent_index      = out_q.parent_index;
	assign rsp.has_parent        = out_q.has_parent;
	assign rsp.first_child_index = out_q.first_child_index;
	assign rsp.child_total       = out_q.child_total;
	assign rsp.node_depth        = out_q.node_depth;
	assign rsp.table_count       = out_table_q;
	assign rsp.tree_count        = out_tree_q;

endmodule

/* rtl/atn_chk.sv */
// ----------------------------------------------------------------------------
// atn_chk
// Port-level checks on the node table, bound to the top level.
// ----------------------------------------------------------------------------
module atn_chk import atn_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [STATUS_BITS-1:0] rsp_status,
	input logic [INDEX_BITS-1:0]  rsp_result_index,
	input logic [DATA_BITS-1:0]   rsp_node_value,
	input logic                   rsp_has_parent,
	input logic [TCOUNT_BITS-1:0] rsp_table_count,
	input logic [DATA_BITS-1:0]   rsp_tree_count
);

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Track requests whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_acc) - 2'(rsp_acc);
		end
	end

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_result_index) && $stable(rsp_node_value) &&
		$stable(rsp_tree_count))
		else $error("stalled result changed");

	// At most one result waits when a new request is taken
	a_one_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> pend_q <= 2'd1)
		else $error("request taken with two results outstanding");

	// No result without a request
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result without a request");

	// A node with a parent comes only from a good read of a non-root entry
	a_parent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_has_parent |-> rsp_status == ST_OK && rsp_result_index != '0)
		else $error("parent flag on a non-read result");

	// Every table entry is counted in the tree total
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> DATA_BITS'(rsp_table_count) <= rsp_tree_count)
		else $error("table count above tree count");

endmodule

bind array_tree_node_store atn_chk u_atn_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_result_index (rsp.result_index),
	.rsp_node_value   (rsp.node_value),
	.rsp_has_parent   (rsp.has_parent),
	.rsp_table_count  (rsp.table_count),
	.rsp_tree_count   (rsp.tree_count)
);
